@@ src/qwt_pkg.sv @@
`default_nettype none

package qwt_pkg;

  localparam logic [7:0] CharBackslash = 8'h5C;
  localparam logic [7:0] CharDquote    = 8'h22;
  localparam logic [7:0] CharSquote    = 8'h27;
  localparam logic [7:0] CharSpace     = 8'h20;
  localparam logic [7:0] CharTab       = 8'h09;
  localparam logic [7:0] CharLf        = 8'h0A;
  localparam logic [7:0] CharCr        = 8'h0D;
  localparam logic [7:0] CharLowerN    = 8'h6E;
  localparam logic [7:0] CharLowerT    = 8'h74;
  localparam logic [7:0] CharLowerR    = 8'h72;

  typedef enum logic [1:0] {
    QUOTE_NONE,
    QUOTE_SINGLE,
    QUOTE_DOUBLE
  } quote_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_INCOMPLETE,
    ST_BAD_ESCAPE,
    ST_UNCLOSED
  } status_e;

  typedef struct packed {
    quote_e  open_quote;
    logic    escape_pending;
    logic    token_nonempty;
    status_e error_seen;
  } state_t;

  typedef struct packed {
    logic       emit;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       token_end;
    logic       string_end;
    status_e    status;
  } result_t;

  localparam state_t StateReset = '{
    open_quote:     QUOTE_NONE,
    escape_pending: 1'b0,
    token_nonempty: 1'b0,
    error_seen:     ST_OK
  };

  // Escape sequences that are accepted after a backslash.
  function automatic logic is_escapable(input logic [7:0] b);
    logic ok;
    case (b) inside
      CharBackslash, CharDquote, CharSquote, CharSpace,
      CharLowerN, CharLowerT, CharLowerR: ok = 1'b1;
      default:                            ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic logic [7:0] escape_value(input logic [7:0] b);
    logic [7:0] v;
    case (b)
      CharLowerN: v = CharLf;
      CharLowerT: v = CharTab;
      CharLowerR: v = CharCr;
      default:    v = b;
    endcase
    return v;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    logic sp;
    case (b) inside
      CharSpace, CharTab, CharLf, CharCr: sp = 1'b1;
      default:                            sp = 1'b0;
    endcase
    return sp;
  endfunction

endpackage

`default_nettype wire

@@ src/qwt_if.sv @@
`default_nettype none

interface qwt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_end;

  modport source (output valid, output in_byte, output is_end, input ready);
  modport sink   (input valid, input in_byte, input is_end, output ready);
endinterface

interface qwt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       token_end;
  logic       string_end;
  logic [1:0] status;

  modport source (output valid, output out_byte, output byte_valid, output token_end,
                  output string_end, output status, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input token_end,
                  input string_end, input status, output ready);
endinterface

`default_nettype wire

@@ src/quoted_word_tokenizer.sv @@
// Channel   Dir  Payload                                               Result count
// in_i      in   in_byte[7:0], is_end                                  -
// out_o     out  out_byte[7:0], byte_valid, token_end, string_end,     0 or 1 per input
//                status[1:0]
//
// An input transfer lands in an input register; the item's result is formed from
// that register and the tokenizer state and written to the output register once
// that register is free. One item per cycle is sustained unless a result waits
// on a stalled output; the state register closes a loop through the step logic.
// Reset clears the pipeline valid flags and the tokenizer state; no clearing pass.
// A stalled output only holds back items that produce a result; items without a
// result keep passing through the input register while a finished result waits.
`default_nettype none

module quoted_word_tokenizer
  import qwt_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  qwt_in_if.sink     in_i,
  qwt_out_if.source  out_o
);

  // Input register stage.
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_end_q;

  // Tokenizer state, updated when the item in the input register moves on.
  state_t state_q, state_d, state_next;

  // Output register.
  logic    out_valid_q, out_valid_d;
  result_t out_q;

  result_t res;
  logic    out_free;
  logic    s1_adv;
  logic    in_fire;

  qwt_step u_step (
    .state_i   (state_q),
    .in_byte_i (s1_byte_q),
    .is_end_i  (s1_end_q),
    .state_o   (state_next),
    .result_o  (res)
  );

  // Items with no result retire without waiting for the output register.
  assign out_free   = !out_valid_q || out_o.ready;
  assign s1_adv     = s1_valid_q && (!res.emit || out_free);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  assign state_d = s1_adv ? state_next : state_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv && res.emit) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= StateReset;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= in_i.in_byte;
      s1_end_q  <= in_i.is_end;
    end
    if (s1_adv && res.emit) begin
      out_q <= res;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_byte   = out_q.out_byte;
  assign out_o.byte_valid = out_q.byte_valid;
  assign out_o.token_end  = out_q.token_end;
  assign out_o.string_end = out_q.string_end;
  assign out_o.status     = out_q.status;

  // A nonzero status only accompanies the end-of-string result.
  a_status_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.string_end |-> out_o.status == ST_OK)
    else $error("status set on a result other than end of string");

  // A result never both carries a byte and closes a token.
  a_byte_xor_tend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.byte_valid && out_o.token_end))
    else $error("byte and token end on the same result");

  // An end marker returns all state to its reset value.
  a_end_resets_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_end_q |=> state_q == StateReset)
    else $error("state not cleared after end marker");

  // A recorded error holds until the end marker retires.
  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.error_seen != ST_OK && !(s1_adv && s1_end_q) |=> $stable(state_q.error_seen))
    else $error("error cleared before end of string");

  // Nothing is written to the output register while it holds an untaken result.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_q))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

@@ src/qwt_step.sv @@
`default_nettype none

module qwt_step
  import qwt_pkg::*;
(
  input  state_t     state_i,
  input  logic [7:0] in_byte_i,
  input  logic       is_end_i,
  output state_t     state_o,
  output result_t    result_o
);

  quote_e q;

  always_comb begin
    if (in_byte_i == CharSquote) begin
      q = QUOTE_SINGLE;
    end else if (in_byte_i == CharDquote) begin
      q = QUOTE_DOUBLE;
    end else begin
      q = QUOTE_NONE;
    end
  end

  always_comb begin
    state_o  = state_i;
    result_o = '{emit: 1'b0, out_byte: 8'h00, byte_valid: 1'b0, token_end: 1'b0,
                 string_end: 1'b0, status: ST_OK};

    if (is_end_i) begin
      state_o             = StateReset;
      result_o.emit       = 1'b1;
      result_o.token_end  = state_i.token_nonempty;
      result_o.string_end = 1'b1;
      if (state_i.open_quote != QUOTE_NONE) begin
        result_o.status = ST_UNCLOSED;
      end else if (state_i.escape_pending && state_i.error_seen == ST_OK) begin
        result_o.status = ST_INCOMPLETE;
      end else begin
        result_o.status = state_i.error_seen;
      end
    end else if (state_i.error_seen != ST_OK) begin
      // Bytes after an error are dropped until the end marker.
    end else if (state_i.escape_pending) begin
      state_o.escape_pending = 1'b0;
      if (!is_escapable(in_byte_i)) begin
        state_o.error_seen = ST_BAD_ESCAPE;
      end else begin
        state_o.token_nonempty = 1'b1;
        result_o.emit          = 1'b1;
        result_o.byte_valid    = 1'b1;
        result_o.out_byte      = escape_value(in_byte_i);
      end
    end else if (in_byte_i == CharBackslash) begin
      state_o.escape_pending = 1'b1;
    end else if (state_i.open_quote != QUOTE_NONE) begin
      if (q == state_i.open_quote) begin
        state_o.open_quote     = QUOTE_NONE;
        state_o.token_nonempty = 1'b0;
        result_o.emit          = 1'b1;
        result_o.token_end     = 1'b1;
      end else begin
        state_o.token_nonempty = 1'b1;
        result_o.emit          = 1'b1;
        result_o.byte_valid    = 1'b1;
        result_o.out_byte      = in_byte_i;
      end
    end else if (q != QUOTE_NONE) begin
      state_o.open_quote = q;
    end else if (is_space(in_byte_i)) begin
      if (state_i.token_nonempty) begin
        state_o.token_nonempty = 1'b0;
        result_o.emit          = 1'b1;
        result_o.token_end     = 1'b1;
      end
    end else begin
      state_o.token_nonempty = 1'b1;
      result_o.emit          = 1'b1;
      result_o.byte_valid    = 1'b1;
      result_o.out_byte      = in_byte_i;
    end
  end

endmodule

`default_nettype wire

@@ bench/tb.sv @@
`default_nettype none

module tb;
  import qwt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Stop generating random strings once this many bytes and end markers
  // have actually been consumed by the tokenizer. Bytes swallowed after a
  // bad escape do not count.
  localparam int unsigned ItemTarget = 760;

  // One token event as it leaves the block on the output channel.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       token_end;
    logic       string_end;
    status_e    status;
  } token_ev_t;

  logic clk;
  logic rst_n;

  qwt_in_if  in_if ();
  qwt_out_if out_if ();

  quoted_word_tokenizer dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Token events the tokenizer still owes us, oldest first.
  token_ev_t   token_events_q[$];
  int unsigned error_count;
  int unsigned items_sent;

  // Shared idle switch: when set, the sender and the receiver each draw a
  // random wait before every transfer. When clear, both run flat out.
  bit          idle_on;
  // A nonzero value asks the receiver to drop ready for that many cycles.
  int unsigned rx_hold_req;

  // Our own copy of the splitter state.
  quote_e      open_q;
  logic        esc_pend;
  logic        tok_busy;
  status_e     err_seen;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog. The slowest legal run is well under a tenth of this.
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Character classes and escape decoding, written independently of the
  // design package helpers.
  // ---------------------------------------------------------------------

  function automatic bit is_blank(input logic [7:0] b);
    case (b)
      CharSpace, CharTab, CharLf, CharCr: return 1'b1;
      default:                            return 1'b0;
    endcase
  endfunction

  // Returns 1 and the decoded character when b may follow a backslash.
  function automatic bit decode_escape(input logic [7:0] b, output logic [7:0] v);
    v = 8'h00;
    case (b)
      CharBackslash, CharDquote, CharSquote, CharSpace: v = b;
      CharLowerN: v = CharLf;
      CharLowerT: v = CharTab;
      CharLowerR: v = CharCr;
      default:    return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic logic [7:0] escape_letter(input int unsigned idx);
    case (idx)
      0:       return CharBackslash;
      1:       return CharDquote;
      2:       return CharSquote;
      3:       return CharSpace;
      4:       return CharLowerN;
      5:       return CharLowerT;
      default: return CharLowerR;
    endcase
  endfunction

  function automatic logic [7:0] quote_char(input quote_e q);
    return (q == QUOTE_SINGLE) ? CharSquote : CharDquote;
  endfunction

  function automatic void clear_tokenizer_state();
    open_q   = QUOTE_NONE;
    esc_pend = 1'b0;
    tok_busy = 1'b0;
    err_seen = ST_OK;
  endfunction

  // Advances the splitter state by one input item and queues the token
  // event it causes, if any. Returns 0 when the item was swallowed because
  // a bad escape was already recorded for this string.
  function automatic bit tokenize_item(input logic [7:0] b, input logic fin);
    token_ev_t  ev;
    quote_e     q;
    logic [7:0] dec;
    bit         emit_it;
    ev      = '0;
    emit_it = 1'b0;
    if (fin) begin
      // A backslash left hanging only counts when nothing worse came first.
      if (esc_pend && err_seen == ST_OK) err_seen = ST_INCOMPLETE;
      ev.token_end  = tok_busy;
      ev.string_end = 1'b1;
      ev.status     = (open_q != QUOTE_NONE) ? ST_UNCLOSED : err_seen;
      clear_tokenizer_state();
      emit_it = 1'b1;
    end else if (err_seen != ST_OK) begin
      return 1'b0;
    end else if (esc_pend) begin
      esc_pend = 1'b0;
      if (decode_escape(b, dec)) begin
        tok_busy      = 1'b1;
        ev.out_byte   = dec;
        ev.byte_valid = 1'b1;
        emit_it       = 1'b1;
      end else begin
        err_seen = ST_BAD_ESCAPE;
      end
    end else if (b == CharBackslash) begin
      esc_pend = 1'b1;
    end else begin
      q = (b == CharSquote) ? QUOTE_SINGLE : (b == CharDquote) ? QUOTE_DOUBLE : QUOTE_NONE;
      if (open_q != QUOTE_NONE) begin
        // Inside quotes everything but the matching quote is literal text.
        if (q == open_q) begin
          open_q       = QUOTE_NONE;
          tok_busy     = 1'b0;
          ev.token_end = 1'b1;
        end else begin
          tok_busy      = 1'b1;
          ev.out_byte   = b;
          ev.byte_valid = 1'b1;
        end
        emit_it = 1'b1;
      end else if (q != QUOTE_NONE) begin
        open_q = q;
      end else if (is_blank(b)) begin
        if (tok_busy) begin
          tok_busy     = 1'b0;
          ev.token_end = 1'b1;
          emit_it      = 1'b1;
        end
      end else begin
        tok_busy      = 1'b1;
        ev.out_byte   = b;
        ev.byte_valid = 1'b1;
        emit_it       = 1'b1;
      end
    end
    if (emit_it) token_events_q = {token_events_q, ev};
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // Input side. Payload changes at the falling edge; the transfer is seen
  // at the rising edge where valid and ready are both high. The first
  // statement always waits for a fresh falling edge, so valid is never
  // assigned twice in one time step, and it stays high between
  // back-to-back transfers.
  // ---------------------------------------------------------------------

  task automatic send_item(input logic [7:0] b, input logic fin);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= b;
    in_if.is_end  <= fin;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    if (tokenize_item(b, fin)) items_sent++;
  endtask

  // Stops offering input and waits until every owed token event is back.
  task automatic pause_until_drained();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (token_events_q.size() != 0) @(posedge clk);
  endtask

  // Ordinary token text: never a quote, backslash or blank. Mostly
  // printable, sometimes any other byte value.
  function automatic logic [7:0] pick_word_byte();
    logic [7:0] b;
    do begin
      if ($urandom_range(0, 4) == 0) b = 8'($urandom);
      else b = 8'($urandom_range(33, 126));
    end while (b == CharBackslash || b == CharDquote || b == CharSquote || is_blank(b));
    return b;
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 3))
      0:       return CharSpace;
      1:       return CharTab;
      2:       return CharLf;
      default: return CharCr;
    endcase
  endfunction

  // Sends one string of up to n_bytes random pieces and its end marker. The
  // generator tracks which quote it opened so that most quoted runs are
  // closed properly. With faults allowed, a few bad escapes, hanging
  // backslashes and raw bytes are mixed in.
  task automatic send_random_string(input int unsigned n_bytes, input bit faults);
    quote_e      q_open;
    int unsigned pick;
    logic [7:0]  b;
    logic [7:0]  dummy;
    bit          stop;
    q_open = QUOTE_NONE;
    stop   = 1'b0;
    for (int unsigned i = 0; i < n_bytes && !stop; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_item(pick_word_byte(), 1'b0);
      end else if (pick < 60) begin
        send_item(pick_blank(), 1'b0);
      end else if (pick < 72) begin
        if (q_open == QUOTE_NONE) begin
          q_open = ($urandom_range(0, 1) != 0) ? QUOTE_SINGLE : QUOTE_DOUBLE;
          send_item(quote_char(q_open), 1'b0);
        end else if ($urandom_range(0, 3) != 0) begin
          send_item(quote_char(q_open), 1'b0);
          q_open = QUOTE_NONE;
        end else begin
          // The other kind of quote is plain text inside the open run.
          send_item(quote_char(q_open == QUOTE_SINGLE ? QUOTE_DOUBLE : QUOTE_SINGLE), 1'b0);
        end
      end else if (pick < 84) begin
        send_item(CharBackslash, 1'b0);
        send_item(escape_letter($urandom_range(0, 6)), 1'b0);
      end else if (faults && pick < 88) begin
        do b = 8'($urandom); while (decode_escape(b, dummy));
        send_item(CharBackslash, 1'b0);
        send_item(b, 1'b0);
      end else if (faults && pick < 90) begin
        // Backslash right before the end marker.
        send_item(CharBackslash, 1'b0);
        stop = 1'b1;
      end else if (faults && pick < 95) begin
        send_item(8'($urandom), 1'b0);
      end else begin
        send_item(pick_word_byte(), 1'b0);
      end
    end
    if (!stop && q_open != QUOTE_NONE && $urandom_range(0, 3) != 0) begin
      send_item(quote_char(q_open), 1'b0);
    end
    send_item(8'($urandom), 1'b1);
  endtask

  // ---------------------------------------------------------------------
  // Output side. The receiver draws a wait before each transfer; a long
  // hold request from a test replaces the draw. While ready is high and
  // nothing arrives, it keeps listening for a new hold request so that one
  // can take effect even when the output is quiet.
  // ---------------------------------------------------------------------

  initial begin : result_receiver
    int unsigned stall;
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (rx_hold_req != 0) begin
        stall       = rx_hold_req;
        rx_hold_req = 0;
      end else begin
        stall = idle_on ? $urandom_range(0, 9) : 0;
      end
      if (stall != 0) begin
        @(negedge clk);
        out_if.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_if.ready <= 1'b1;
      do @(posedge clk); while (out_if.valid !== 1'b1 && rx_hold_req == 0);
    end
  end

  // Every transfer on the output is matched against the oldest owed event.
  initial begin : token_checker
    token_ev_t exp;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        if (token_events_q.size() == 0) begin
          $error("unexpected transfer: out_byte %02h byte_valid %0b token_end %0b %s %0b %s %0d",
                 out_if.out_byte, out_if.byte_valid, out_if.token_end,
                 "string_end", out_if.string_end, "status", out_if.status);
          error_count++;
        end else begin
          exp = token_events_q.pop_front();
          if (out_if.out_byte !== exp.out_byte) begin
            $error("out_byte: expected %02h, got %02h", exp.out_byte, out_if.out_byte);
            error_count++;
          end
          if (out_if.byte_valid !== exp.byte_valid) begin
            $error("byte_valid: expected %0b, got %0b", exp.byte_valid, out_if.byte_valid);
            error_count++;
          end
          if (out_if.token_end !== exp.token_end) begin
            $error("token_end: expected %0b, got %0b", exp.token_end, out_if.token_end);
            error_count++;
          end
          if (out_if.string_end !== exp.string_end) begin
            $error("string_end: expected %0b, got %0b", exp.string_end, out_if.string_end);
            error_count++;
          end
          if (out_if.status !== exp.status) begin
            $error("status: expected %0d, got %0d", exp.status, out_if.status);
            error_count++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------

  // Zero and all-ones bytes as tokens, every blank character, both with
  // and without a token to close, and a token flushed by the end marker.
  task automatic test_blank_splitting();
    send_item(8'h00, 1'b0);
    send_item(CharSpace, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(CharTab, 1'b0);
    send_item(CharLf, 1'b0);
    send_item(CharCr, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b1);
    pause_until_drained();
  endtask

  // Text joined to a quoted run, the other quote as literal text, an empty
  // quoted token, and a quote still open at the end marker.
  task automatic test_quoting();
    send_item("x", 1'b0);
    send_item(CharSquote, 1'b0);
    send_item(CharDquote, 1'b0);
    send_item(CharSquote, 1'b0);
    send_item(CharDquote, 1'b0);
    send_item(CharDquote, 1'b0);
    send_item(CharSquote, 1'b0);
    send_item(8'h00, 1'b1);
    pause_until_drained();
  endtask

  // All seven escapes, then a backslash cut off by the end marker.
  task automatic test_escapes();
    for (int unsigned i = 0; i < 7; i++) begin
      send_item(CharBackslash, 1'b0);
      send_item(escape_letter(i), 1'b0);
    end
    send_item(CharBackslash, 1'b0);
    send_item(8'h7F, 1'b1);
    pause_until_drained();
  endtask

  // A backslash followed by byte zero; the byte after it must be ignored.
  task automatic test_bad_escape();
    send_item(CharBackslash, 1'b0);
    send_item(8'h00, 1'b0);
    send_item("y", 1'b0);
    send_item(8'h00, 1'b1);
    pause_until_drained();
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering text bytes, so the block fills and must stall its input.
  task automatic test_output_stall();
    idle_on     = 1'b0;
    rx_hold_req = 150;
    wait (rx_hold_req == 0);
    repeat (40) send_item(pick_word_byte(), 1'b0);
    send_item(8'($urandom), 1'b1);
    pause_until_drained();
    idle_on = 1'b1;
  endtask

  // Mostly well-formed strings with random content, some carrying faults,
  // and occasional bursts of raw noise. Idling is switched per string.
  task automatic test_random_strings();
    int unsigned kind;
    while (items_sent < ItemTarget) begin
      idle_on = ($urandom_range(0, 3) != 0);
      kind    = $urandom_range(0, 9);
      if (kind == 0) begin
        repeat ($urandom_range(1, 8)) send_item(8'($urandom), $urandom_range(0, 7) == 0);
      end else begin
        send_random_string($urandom_range(0, 24), kind <= 2);
      end
    end
    pause_until_drained();
  endtask

  initial begin
    in_if.valid   = 1'b0;
    in_if.in_byte = 8'h00;
    in_if.is_end  = 1'b0;
    rst_n         = 1'b0;
    idle_on       = 1'b1;
    rx_hold_req   = 0;
    error_count   = 0;
    items_sent    = 0;
    clear_tokenizer_state();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    test_blank_splitting();
    test_quoting();
    test_escapes();
    test_bad_escape();
    test_output_stall();
    test_random_strings();

    // Everything owed has arrived; keep watching the output before the verdict
    // so that any stray transfer is caught.
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
